/* sv/scba_pkg.sv */
package scba_pkg;

	// Request modes
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	// Response status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_NO_MEM    = 2'd2;

	// Work kind of the pending request, reported to the controller
	localparam logic [1:0] KIND_IMM   = 2'd0;
	localparam logic [1:0] KIND_POP   = 2'd1;
	localparam logic [1:0] KIND_CLAIM = 2'd2;

	// Size class bounds in bytes
	localparam logic [15:0] CLASS0_MAX = 16'd64;
	localparam logic [15:0] CLASS1_MAX = 16'd128;
	localparam logic [15:0] CLASS2_MAX = 16'd256;
	localparam logic [15:0] CLASS3_MAX = 16'd512;

	localparam int          NUM_CLASSES = 4;
	localparam int          LINK_DEPTH  = 4096;
	localparam int          HANDLE_W    = 12;
	localparam int          CNT_W       = 11;
	localparam logic [10:0] CNT_MAX     = 11'd1024;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] req_size;
		logic [11:0] handle;
		logic [1:0]  query_class;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] block_id;
		logic [1:0]  size_class;
		logic [10:0] used_blocks;
		logic [10:0] spare_blocks;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;  // capture the accepted request
		logic exec;   // commit a non-pop request and load the response
		logic pop;    // commit a list pop with the link read data
		logic fill;   // write one link entry of a new slab
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] kind;
		logic       fill_last;
	} stat_t;

	// Handle layout: class(2) | slab(4) | block(6); wider numbers are cut
	function automatic logic [11:0] make_handle(input logic [1:0] cls,
		input logic [6:0] slab, input logic [7:0] blk);
		make_handle = {cls, slab[3:0], blk[5:0]};
	endfunction

endpackage

/* sv/size_class_block_allocator_core.sv */
// Block allocator with four size classes (64, 128, 256, 512 bytes), each a
// free list threaded through a 4096-entry link RAM. One request is in work at
// a time; the response sits in an output register, so a new request is taken
// while the last response waits. Free, query, clear and rejected requests
// are committed from the execute state. An allocate from a non-empty list
// goes on to a pop state, for the registered read of the link RAM at the list
// head. An allocate that claims a fresh slab commits its response, then
// writes the slab's links one per cycle, and the next request is taken only
// once that fill is done. A commit waits while the response register is full.
module size_class_block_allocator_core #(
	parameter int SLABS_PER_CLASS  = 16,
	parameter int BLOCKS_EACH_SLAB = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  scba_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output scba_pkg::rsp_t  rsp_data
);

	scba_pkg::cmd_t  cmd;
	scba_pkg::stat_t stat;

	scba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	scba_dp #(
		.SLABS_PER_CLASS (SLABS_PER_CLASS),
		.BLOCKS_EACH_SLAB(BLOCKS_EACH_SLAB)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_data(req_data),
		.cmd     (cmd),
		.stat    (stat),
		.rsp_data(rsp_data)
	);

`ifndef NO_ASSERTIONS
	// a response is only committed when the output register is free
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.pop) |-> (!rsp_valid || rsp_ready))
		else $error("response committed over a pending response");

	// a commit always shows up as a valid response
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.pop) |=> rsp_valid)
		else $error("committed response not presented");

	// no request taken while a slab fill is running
	a_fill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> !req_ready)
		else $error("request accepted during slab fill");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status == scba_pkg::ST_OK ||
			rsp_data.status == scba_pkg::ST_TOO_LARGE ||
			rsp_data.status == scba_pkg::ST_NO_MEM))
		else $error("undefined response status");
`endif

endmodule

/* sv/scba_ram.sv */
module scba_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/scba_ctrl.sv */
module scba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output scba_pkg::cmd_t       cmd,
	input  scba_pkg::stat_t      stat
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_FILL = 2'd3;

	logic [1:0] state_q, state_d;
	logic       rsp_vld_q;
	logic       rsp_room;

	// response register can take a new value this cycle
	assign rsp_room = !rsp_vld_q || rsp_ready;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.kind == scba_pkg::KIND_POP) begin
					// link read of the list head is in flight
					state_d = S_POP;
				end else if (rsp_room) begin
					cmd.exec = 1'b1;
					state_d  = (stat.kind == scba_pkg::KIND_CLAIM) ? S_FILL : S_IDLE;
				end
			end
			S_POP: begin
				if (rsp_room) begin
					cmd.pop = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.fill_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec || cmd.pop) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_vld_q;

endmodule

/* sv/scba_dp.sv */
module scba_dp #(
	parameter int SLABS_PER_CLASS  = 16,
	parameter int BLOCKS_EACH_SLAB = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scba_pkg::req_t    req_data,
	input  scba_pkg::cmd_t    cmd,
	output scba_pkg::stat_t   stat,
	output scba_pkg::rsp_t    rsp_data
);

	localparam int SW = $clog2(SLABS_PER_CLASS + 1);
	localparam int BW = $clog2(BLOCKS_EACH_SLAB);
	localparam int NC = scba_pkg::NUM_CLASSES;
	localparam int HW = scba_pkg::HANDLE_W;
	localparam int CW = scba_pkg::CNT_W;
	localparam logic [CW-1:0] SPARE_INIT = CW'(BLOCKS_EACH_SLAB - 1);
	localparam logic [BW-1:0] BLK_LAST   = BW'(BLOCKS_EACH_SLAB - 1);
	localparam logic [SW-1:0] SLAB_LIMIT = SW'(SLABS_PER_CLASS);

	scba_pkg::req_t req_q;
	scba_pkg::rsp_t rsp_q, rsp_nx;

	logic          head_vld_q [NC];
	logic [HW-1:0] head_q     [NC];
	logic [SW-1:0] slabs_q    [NC];
	logic [CW-1:0] used_q     [NC];
	logic [CW-1:0] spare_q    [NC];

	logic [BW-1:0] fill_blk_q;
	logic [1:0]    fill_cls_q;
	logic [SW-1:0] fill_slab_q;

	logic [1:0]    cls_pick, cls;
	logic          too_large;
	logic          hv, can_pop, slabs_full;
	logic [HW-1:0] hh;
	logic [CW-1:0] used_cur, spare_cur, used_inc, used_dec, spare_inc, spare_dec;
	logic [6:0]    slab_w;
	logic          free_ok;

	logic          ram_we;
	logic [HW-1:0] ram_waddr, ram_wdata, ram_rdata;
	logic [HW-1:0] fill_addr, fill_data;
	logic          fill_last;

	// size class selection; a size of zero falls into the smallest class
	always_comb begin
		too_large = 1'b0;
		cls_pick  = 2'd0;
		if (req_q.req_size <= scba_pkg::CLASS0_MAX) begin
			cls_pick = 2'd0;
		end else if (req_q.req_size <= scba_pkg::CLASS1_MAX) begin
			cls_pick = 2'd1;
		end else if (req_q.req_size <= scba_pkg::CLASS2_MAX) begin
			cls_pick = 2'd2;
		end else if (req_q.req_size <= scba_pkg::CLASS3_MAX) begin
			cls_pick = 2'd3;
		end else begin
			too_large = 1'b1;
		end
	end

	assign cls = (req_q.mode == scba_pkg::MODE_QUERY) ? req_q.query_class : cls_pick;

	// per-class state of the selected class
	assign hv         = head_vld_q[cls];
	assign hh         = head_q[cls];
	assign used_cur   = used_q[cls];
	assign spare_cur  = spare_q[cls];
	assign can_pop    = hv && (spare_cur != '0);
	assign slabs_full = slabs_q[cls] >= SLAB_LIMIT;
	assign slab_w     = 7'(slabs_q[cls]);
	assign free_ok    = (req_q.mode == scba_pkg::MODE_FREE) && !too_large;

	// counter updates; all but spare_dec saturate
	assign used_inc  = (used_cur == scba_pkg::CNT_MAX) ? used_cur : used_cur + CW'(1);
	assign used_dec  = (used_cur == '0) ? used_cur : used_cur - CW'(1);
	assign spare_inc = (spare_cur == scba_pkg::CNT_MAX) ? spare_cur : spare_cur + CW'(1);
	assign spare_dec = spare_cur - CW'(1);

	// work kind and fill status for the controller
	always_comb begin
		stat.kind      = scba_pkg::KIND_IMM;
		stat.fill_last = fill_last;
		if (req_q.mode == scba_pkg::MODE_ALLOC && !too_large) begin
			if (can_pop) begin
				stat.kind = scba_pkg::KIND_POP;
			end else if (!slabs_full) begin
				stat.kind = scba_pkg::KIND_CLAIM;
			end
		end
	end

	// slab fill sweep: block b links to b+1, the last block ends the list
	assign fill_last      = fill_blk_q == BLK_LAST;
	assign fill_addr      = scba_pkg::make_handle(fill_cls_q, 7'(fill_slab_q), 8'(fill_blk_q));
	assign fill_data      = fill_last ? '0 :
		scba_pkg::make_handle(fill_cls_q, 7'(fill_slab_q), 8'(fill_blk_q) + 8'd1);

	// link memory write port: slab fill or free push
	assign ram_we    = cmd.fill || (cmd.exec && free_ok);
	assign ram_waddr = cmd.fill ? fill_addr : req_q.handle;
	assign ram_wdata = cmd.fill ? fill_data : (hv ? hh : '0);

	scba_ram #(
		.WIDTH(HW),
		.DEPTH(scba_pkg::LINK_DEPTH)
	) u_link (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(hh),
		.rdata(ram_rdata)
	);

	// response of the pending request
	always_comb begin
		rsp_nx = '0;
		unique case (req_q.mode)
			scba_pkg::MODE_ALLOC: begin
				if (too_large) begin
					rsp_nx.status = scba_pkg::ST_TOO_LARGE;
				end else if (can_pop) begin
					rsp_nx.block_id     = hh;
					rsp_nx.size_class   = cls;
					rsp_nx.used_blocks  = used_inc;
					rsp_nx.spare_blocks = spare_dec;
				end else if (slabs_full) begin
					rsp_nx.status       = scba_pkg::ST_NO_MEM;
					rsp_nx.size_class   = cls;
					rsp_nx.used_blocks  = used_cur;
					rsp_nx.spare_blocks = spare_cur;
				end else begin
					rsp_nx.block_id     = scba_pkg::make_handle(cls, slab_w, 8'd0);
					rsp_nx.size_class   = cls;
					rsp_nx.used_blocks  = used_inc;
					rsp_nx.spare_blocks = SPARE_INIT;
				end
			end
			scba_pkg::MODE_FREE: begin
				if (too_large) begin
					rsp_nx.status = scba_pkg::ST_TOO_LARGE;
				end else begin
					rsp_nx.size_class   = cls;
					rsp_nx.used_blocks  = used_dec;
					rsp_nx.spare_blocks = spare_inc;
				end
			end
			scba_pkg::MODE_QUERY: begin
				rsp_nx.size_class   = cls;
				rsp_nx.used_blocks  = used_cur;
				rsp_nx.spare_blocks = spare_cur;
			end
			default: rsp_nx = '0;
		endcase
	end

	// class bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				head_vld_q[i] <= 1'b0;
				slabs_q[i]    <= '0;
				used_q[i]     <= '0;
				spare_q[i]    <= '0;
			end
		end else begin
			if (cmd.exec) begin
				if (req_q.mode == scba_pkg::MODE_CLEAR) begin
					for (int i = 0; i < NC; i++) begin
						head_vld_q[i] <= 1'b0;
						slabs_q[i]    <= '0;
						used_q[i]     <= '0;
						spare_q[i]    <= '0;
					end
				end else if (free_ok) begin
					head_vld_q[cls] <= 1'b1;
					spare_q[cls]    <= spare_inc;
					used_q[cls]     <= used_dec;
				end else if (stat.kind == scba_pkg::KIND_CLAIM) begin
					head_vld_q[cls] <= 1'b1;
					slabs_q[cls]    <= slabs_q[cls] + SW'(1);
					spare_q[cls]    <= SPARE_INIT;
					used_q[cls]     <= used_inc;
				end
			end
			if (cmd.pop) begin
				spare_q[cls] <= spare_dec;
				used_q[cls]  <= used_inc;
				if (spare_dec == '0) begin
					head_vld_q[cls] <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_data;
		end
		if (cmd.exec || cmd.pop) begin
			rsp_q <= rsp_nx;
		end
		if (cmd.exec && free_ok) begin
			head_q[cls] <= req_q.handle;
		end
		if (cmd.exec && stat.kind == scba_pkg::KIND_CLAIM) begin
			head_q[cls] <= scba_pkg::make_handle(cls, slab_w, 8'd1);
			fill_blk_q  <= BW'(1);
			fill_cls_q  <= cls;
			fill_slab_q <= slabs_q[cls];
		end
		if (cmd.pop) begin
			head_q[cls] <= ram_rdata;
		end
		if (cmd.fill) begin
			fill_blk_q <= fill_blk_q + BW'(1);
		end
	end

	assign rsp_data = rsp_q;

endmodule
